>>> design/qsb_pkg.sv
// qsb_pkg: shared types and constants for the quadratic stack blur line block
// no dependencies
package qsb_pkg;

    localparam int RAD_W     = 5;
    localparam int MULT_W    = 16;
    localparam int SHIFT_W   = 5;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MULT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SHIFT = 2'd2;

    localparam logic [RAD_W-1:0]   RADIUS_RST = 5'd2;
    localparam logic [MULT_W-1:0]  MULT_RST   = 16'd5461;
    localparam logic [SHIFT_W-1:0] SHIFT_RST  = 5'd16;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam int NUM_SUMS = 7;
    localparam int S_LEFT   = 0;
    localparam int S_RIGHT  = 1;
    localparam int S_LIN    = 2;
    localparam int S_LOUT   = 3;
    localparam int S_RIN    = 4;
    localparam int S_ROUT   = 5;
    localparam int S_QUAD   = 6;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_LOUT_SUB_REM   = 4'd0;
    localparam logic [OP_W-1:0] OP_LIN_ADD_R      = 4'd1;
    localparam logic [OP_W-1:0] OP_LEFT_ADD_LIN   = 4'd2;
    localparam logic [OP_W-1:0] OP_LOUT_ADD_ACC   = 4'd3;
    localparam logic [OP_W-1:0] OP_LIN_SUB_RACC   = 4'd4;
    localparam logic [OP_W-1:0] OP_ROUT_SUB_R1    = 4'd5;
    localparam logic [OP_W-1:0] OP_RIN_ADD_NEW   = 4'd6;
    localparam logic [OP_W-1:0] OP_RIGHT_ADD_RIN  = 4'd7;
    localparam logic [OP_W-1:0] OP_ROUT_ADD_RPACC = 4'd8;
    localparam logic [OP_W-1:0] OP_RIN_SUB_2RACC  = 4'd9;
    localparam logic [OP_W-1:0] OP_QUAD_ADD_RIGHT = 4'd10;
    localparam logic [OP_W-1:0] OP_QUAD_SUB_LEFT  = 4'd11;
    localparam logic [OP_W-1:0] OP_LEFT_SUB_LOUT  = 4'd12;
    localparam logic [OP_W-1:0] OP_RIGHT_SUB_ROUT = 4'd13;

    typedef enum logic [2:0] {
        OFF_NONE,
        OFF_R,
        OFF_ACC,
        OFF_R_ACC,
        OFF_R_1,
        OFF_R_PACC,
        OFF_2R_ACC
    } off_t;

    typedef enum logic [1:0] {
        M_START,
        M_NORM,
        M_DRAIN
    } mode_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WR_HI,
        ST_WR_LO,
        ST_R1I_A,
        ST_R1I_B,
        ST_R1I_C,
        ST_R1I_D,
        ST_R1N_A,
        ST_R1N_B,
        ST_R1N_C,
        ST_R1N_D,
        ST_R1N_E,
        ST_R1L_A,
        ST_R1L_B,
        ST_UA0,
        ST_UA1,
        ST_UA2,
        ST_OPA,
        ST_OPB,
        ST_FIN,
        ST_MUL,
        ST_EMIT
    } state_t;

    function automatic off_t op_offset(input logic [OP_W-1:0] op);
        off_t o;
        case (op)
            OP_LIN_ADD_R:      o = OFF_R;
            OP_LOUT_ADD_ACC:   o = OFF_ACC;
            OP_LIN_SUB_RACC:   o = OFF_R_ACC;
            OP_ROUT_SUB_R1:    o = OFF_R_1;
            OP_ROUT_ADD_RPACC: o = OFF_R_PACC;
            OP_RIN_SUB_2RACC:  o = OFF_2R_ACC;
            default:           o = OFF_NONE;
        endcase
        return o;
    endfunction

endpackage

>>> design/qsb_if.sv
// qsb_if: stream interfaces for pixels in and blurred pixels out
// no dependencies
interface qsb_in_if #(parameter int PIXEL_BITS = 8);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_in;
    logic                  last_in;

    modport source(output valid, output pixel_in, output last_in, input ready);
    modport sink(input valid, input pixel_in, input last_in, output ready);
endinterface

interface qsb_out_if #(parameter int PIXEL_BITS = 8);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  last_out;

    modport source(output valid, output pixel_out, output last_out, input ready);
    modport sink(input valid, input pixel_out, input last_out, output ready);
endinterface

>>> design/qsb_ram.sv
// qsb_ram: generic single write port ram with one registered read port
// no dependencies
module qsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 41
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/qsb_front.sv
// qsb_front: input side, accepts pixels into a short queue for the back end
// depends on qsb_pkg and qsb_if
module qsb_front #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    qsb_in_if.sink                in_ch,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output logic [PIXEL_BITS-1:0] pop_pixel,
    output logic                  pop_last
);

    logic [PIXEL_BITS:0]          q_mem [qsb_pkg::Q_DEPTH];
    logic [qsb_pkg::Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [qsb_pkg::Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [qsb_pkg::Q_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                         push, pop;

    assign in_ch.ready = (cnt_reg != qsb_pkg::Q_CNT_W'(qsb_pkg::Q_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign pop_valid   = (cnt_reg != '0);
    assign pop         = pop_valid && pop_ready;
    assign pop_pixel   = q_mem[rd_ptr_reg][PIXEL_BITS-1:0];
    assign pop_last    = q_mem[rd_ptr_reg][PIXEL_BITS];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= {in_ch.last_in, in_ch.pixel_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> design/qsb_back.sv
// qsb_back: sequencer that runs the window, running sums, scaling and output word
// depends on qsb_pkg, qsb_if and qsb_ram
module qsb_back #(
    parameter int MAX_RAD    = 20,
    parameter int PIXEL_BITS = 8,
    parameter int ACC_BITS   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  logic [PIXEL_BITS-1:0]         pop_pixel,
    input  logic                          pop_last,
    input  logic [qsb_pkg::RAD_W-1:0]     radius,
    input  logic [qsb_pkg::MULT_W-1:0]    weight_multiplier,
    input  logic [qsb_pkg::SHIFT_W-1:0]   weight_shift,
    qsb_out_if.source                     out_ch
);

    localparam int WIN  = 2 * MAX_RAD + 1;
    localparam int AW   = $clog2(WIN);
    localparam int XW   = AW + 1;
    localparam int PSW  = $clog2(MAX_RAD + 2);
    localparam int PRW  = ACC_BITS + qsb_pkg::MULT_W;
    localparam int RW   = PRW + 1;

    qsb_pkg::state_t            state_reg, state_next;
    qsb_pkg::mode_t             mode_reg, mode_next;
    logic [ACC_BITS-1:0]        sum_reg [qsb_pkg::NUM_SUMS];
    logic [ACC_BITS-1:0]        sum_next [qsb_pkg::NUM_SUMS];
    logic [AW-1:0]              wi_reg, wi_next;
    logic [PSW-1:0]             ps_reg, ps_next;
    logic [qsb_pkg::RAD_W-1:0]  lr_reg, lr_next;
    logic [AW-1:0]              step_reg, step_next;
    logic [PSW-1:0]             cnt_reg, cnt_next;
    logic [qsb_pkg::OP_W-1:0]   op_reg, op_next;
    logic [PIXEL_BITS-1:0]      p_reg, p_next;
    logic                       last_reg, last_next;
    logic [PIXEL_BITS-1:0]      add_reg, add_next;
    logic [PIXEL_BITS-1:0]      rem_reg, rem_next;
    logic                       zero_reg, zero_next;
    logic [ACC_BITS-1:0]        v_reg, v_next;
    logic [ACC_BITS-1:0]        q_reg, q_next;
    logic [PRW-1:0]             prod_reg, prod_next;
    logic                       em_last_reg, em_last_next;
    logic                       rnd1_reg, rnd1_next;
    logic                       out_valid_reg, out_valid_next;
    logic [PIXEL_BITS-1:0]      out_pixel_reg, out_pixel_next;
    logic                       out_last_reg, out_last_next;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [PIXEL_BITS-1:0]      ram_wdata, ram_rdata;

    logic [XW-1:0]              xr, acc, bs, wi_x, off, t_st, n_sum, d_drain, ps_x, r_in_x;
    logic [AW-1:0]              wi_inc, wi_inc2, st_addr, n_addr, j_addr;
    logic                       st_zero;
    logic [qsb_pkg::RAD_W-1:0]  r_in;
    logic                       r_bad, r_one, in_startup, startup_done;
    logic                       slot_free, step_last;
    logic [ACC_BITS-1:0]        fv;
    logic [RW-1:0]              rnd_add, shifted;
    logic [ACC_BITS:0]          r1_sum;
    logic [PIXEL_BITS-1:0]      emit_val;

    qsb_ram #(
        .WIDTH(PIXEL_BITS),
        .DEPTH(WIN)
    ) u_win (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // window geometry
    always_comb
    begin
        xr      = XW'(lr_reg);
        acc     = xr >> 1;
        bs      = (xr << 1) + XW'(1);
        wi_x    = XW'(wi_reg);
        wi_inc  = ((wi_x + XW'(1)) == bs) ? '0 : wi_reg + AW'(1);
        wi_inc2 = ((XW'(wi_inc) + XW'(1)) == bs) ? '0 : wi_inc + AW'(1);
        case (qsb_pkg::op_offset(op_reg))
            qsb_pkg::OFF_R:      off = xr;
            qsb_pkg::OFF_ACC:    off = acc;
            qsb_pkg::OFF_R_ACC:  off = xr - acc;
            qsb_pkg::OFF_R_1:    off = xr - XW'(1);
            qsb_pkg::OFF_R_PACC: off = xr + acc;
            qsb_pkg::OFF_2R_ACC: off = (xr << 1) - acc;
            default:             off = '0;
        endcase
        t_st    = off + XW'(step_reg) + XW'(1);
        st_zero = (t_st < bs);
        st_addr = AW'(t_st - bs);
        n_sum   = wi_x + off;
        n_addr  = (n_sum >= bs) ? AW'(n_sum - bs) : AW'(n_sum);
        d_drain = (XW'(cnt_reg) + XW'(1)) << 1;
        j_addr  = (wi_x >= d_drain) ? AW'(wi_x - d_drain) : AW'(wi_x + bs - d_drain);
        r_in    = (ps_reg == '0) ? radius : lr_reg;
        r_bad   = (r_in == '0) || (int'(r_in) > MAX_RAD);
        r_in_x  = XW'(r_in);
        ps_x    = XW'(ps_reg);
        in_startup   = (ps_x <= r_in_x);
        startup_done = ((ps_x + XW'(1)) > xr);
        r_one        = (lr_reg == qsb_pkg::RAD_W'(1));
        step_last    = ((XW'(step_reg) + XW'(1)) >= bs);
        slot_free    = !out_valid_reg || out_ch.ready;
        fv           = zero_reg ? '0 : ACC_BITS'(ram_rdata);
    end

    // output scaling
    always_comb
    begin
        rnd_add = RW'(1) << (weight_shift - qsb_pkg::SHIFT_W'(1));
        shifted = (RW'(prod_reg) + rnd_add) >> weight_shift;
        r1_sum  = ((ACC_BITS + 1)'(q_reg) + (ACC_BITS + 1)'(2)) >> 2;
        if (rnd1_reg)
        begin
            emit_val = PIXEL_BITS'(r1_sum);
        end
        else if (weight_shift == '0)
        begin
            emit_val = PIXEL_BITS'(prod_reg);
        end
        else
        begin
            emit_val = PIXEL_BITS'(shifted);
        end
    end

    // window memory ports
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wi_reg;
        ram_wdata = p_reg;
        ram_raddr = wi_reg;
        case (state_reg)
            qsb_pkg::ST_WR_HI:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(xr + ps_x);
            end
            qsb_pkg::ST_WR_LO:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(xr - ps_x);
            end
            qsb_pkg::ST_R1I_A: ram_raddr = AW'(0);
            qsb_pkg::ST_R1I_B: ram_raddr = AW'(1);
            qsb_pkg::ST_R1I_C: ram_raddr = AW'(2);
            qsb_pkg::ST_R1N_A: ram_raddr = wi_reg;
            qsb_pkg::ST_R1N_B:
            begin
                ram_we    = 1'b1;
                ram_raddr = wi_inc2;
            end
            qsb_pkg::ST_R1L_A: ram_raddr = wi_inc;
            qsb_pkg::ST_UA0:
                ram_raddr = (mode_reg == qsb_pkg::M_DRAIN) ? j_addr : step_reg;
            qsb_pkg::ST_UA1: ram_raddr = wi_reg;
            qsb_pkg::ST_UA2:
            begin
                ram_we    = (mode_reg != qsb_pkg::M_START);
                ram_wdata = add_reg;
            end
            qsb_pkg::ST_OPA:
                ram_raddr = (mode_reg == qsb_pkg::M_START) ? st_addr : n_addr;
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qsb_pkg::ST_IDLE:
            begin
                if (pop_valid)
                begin
                    if (r_bad)
                        state_next = qsb_pkg::ST_IDLE;
                    else if (in_startup)
                        state_next = qsb_pkg::ST_WR_HI;
                    else if (r_in == qsb_pkg::RAD_W'(1))
                        state_next = qsb_pkg::ST_R1N_A;
                    else
                        state_next = qsb_pkg::ST_UA0;
                end
            end
            qsb_pkg::ST_WR_HI: state_next = qsb_pkg::ST_WR_LO;
            qsb_pkg::ST_WR_LO:
            begin
                if (!startup_done)
                    state_next = qsb_pkg::ST_IDLE;
                else if (r_one)
                    state_next = qsb_pkg::ST_R1I_A;
                else
                    state_next = qsb_pkg::ST_UA0;
            end
            qsb_pkg::ST_R1I_A: state_next = qsb_pkg::ST_R1I_B;
            qsb_pkg::ST_R1I_B: state_next = qsb_pkg::ST_R1I_C;
            qsb_pkg::ST_R1I_C: state_next = qsb_pkg::ST_R1I_D;
            qsb_pkg::ST_R1I_D: state_next = qsb_pkg::ST_EMIT;
            qsb_pkg::ST_R1N_A: state_next = qsb_pkg::ST_R1N_B;
            qsb_pkg::ST_R1N_B: state_next = qsb_pkg::ST_R1N_C;
            qsb_pkg::ST_R1N_C: state_next = qsb_pkg::ST_R1N_D;
            qsb_pkg::ST_R1N_D: state_next = qsb_pkg::ST_R1N_E;
            qsb_pkg::ST_R1N_E: state_next = qsb_pkg::ST_EMIT;
            qsb_pkg::ST_R1L_A: state_next = qsb_pkg::ST_R1L_B;
            qsb_pkg::ST_R1L_B: state_next = qsb_pkg::ST_EMIT;
            qsb_pkg::ST_UA0:   state_next = qsb_pkg::ST_UA1;
            qsb_pkg::ST_UA1:   state_next = qsb_pkg::ST_UA2;
            qsb_pkg::ST_UA2:   state_next = qsb_pkg::ST_OPA;
            qsb_pkg::ST_OPA:   state_next = qsb_pkg::ST_OPB;
            qsb_pkg::ST_OPB:
            begin
                if (op_reg == qsb_pkg::OP_RIGHT_SUB_ROUT)
                    state_next = qsb_pkg::ST_FIN;
                else
                    state_next = qsb_pkg::ST_OPA;
            end
            qsb_pkg::ST_FIN:
            begin
                if (mode_reg == qsb_pkg::M_START && !step_last)
                    state_next = qsb_pkg::ST_UA0;
                else
                    state_next = qsb_pkg::ST_MUL;
            end
            qsb_pkg::ST_MUL: state_next = qsb_pkg::ST_EMIT;
            qsb_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    if (em_last_reg)
                        state_next = qsb_pkg::ST_IDLE;
                    else if (mode_reg == qsb_pkg::M_DRAIN)
                        state_next = qsb_pkg::ST_UA0;
                    else if (last_reg)
                        state_next = r_one ? qsb_pkg::ST_R1L_A : qsb_pkg::ST_UA0;
                    else
                        state_next = qsb_pkg::ST_IDLE;
                end
            end
            default: state_next = qsb_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        mode_next      = mode_reg;
        sum_next       = sum_reg;
        wi_next        = wi_reg;
        ps_next        = ps_reg;
        lr_next        = lr_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        p_next         = p_reg;
        last_next      = last_reg;
        add_next       = add_reg;
        rem_next       = rem_reg;
        zero_next      = zero_reg;
        v_next         = v_reg;
        q_next         = q_reg;
        prod_next      = prod_reg;
        em_last_next   = em_last_reg;
        rnd1_next      = rnd1_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_pixel_next = out_pixel_reg;
        out_last_next  = out_last_reg;
        pop_ready      = 1'b0;
        case (state_reg)
            qsb_pkg::ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    p_next    = pop_pixel;
                    last_next = pop_last;
                    mode_next = qsb_pkg::M_NORM;
                    if (ps_reg == '0)
                    begin
                        lr_next  = radius;
                        wi_next  = '0;
                        sum_next = '{default: '0};
                    end
                end
            end
            qsb_pkg::ST_WR_LO:
            begin
                ps_next = ps_reg + PSW'(1);
                if (!startup_done)
                begin
                    if (last_reg)
                    begin
                        ps_next  = '0;
                        wi_next  = '0;
                        sum_next = '{default: '0};
                    end
                end
                else
                begin
                    wi_next   = '0;
                    step_next = '0;
                    mode_next = r_one ? qsb_pkg::M_NORM : qsb_pkg::M_START;
                end
            end
            qsb_pkg::ST_R1I_B: add_next = ram_rdata;
            qsb_pkg::ST_R1I_C: rem_next = ram_rdata;
            qsb_pkg::ST_R1I_D:
            begin
                sum_next[qsb_pkg::S_LEFT]  = ACC_BITS'(add_reg) + ACC_BITS'(rem_reg);
                sum_next[qsb_pkg::S_QUAD]  = ACC_BITS'(add_reg) + ACC_BITS'(rem_reg);
                sum_next[qsb_pkg::S_RIGHT] = ACC_BITS'(ram_rdata);
                q_next       = (ACC_BITS'(add_reg) + ACC_BITS'(rem_reg)) << 1;
                rnd1_next    = 1'b1;
                em_last_next = 1'b0;
            end
            qsb_pkg::ST_R1N_B:
            begin
                sum_next[qsb_pkg::S_LEFT] = sum_reg[qsb_pkg::S_LEFT] - ACC_BITS'(ram_rdata);
                wi_next = wi_inc;
            end
            qsb_pkg::ST_R1N_C:
            begin
                rem_next = ram_rdata;
                sum_next[qsb_pkg::S_RIGHT] = sum_reg[qsb_pkg::S_RIGHT] + ACC_BITS'(p_reg);
                sum_next[qsb_pkg::S_LEFT]  = sum_reg[qsb_pkg::S_LEFT] + ACC_BITS'(ram_rdata);
            end
            qsb_pkg::ST_R1N_D:
            begin
                sum_next[qsb_pkg::S_QUAD]  = sum_reg[qsb_pkg::S_QUAD] + sum_reg[qsb_pkg::S_RIGHT];
                q_next = sum_reg[qsb_pkg::S_QUAD] + sum_reg[qsb_pkg::S_RIGHT];
                sum_next[qsb_pkg::S_RIGHT] = sum_reg[qsb_pkg::S_RIGHT] - ACC_BITS'(rem_reg);
            end
            qsb_pkg::ST_R1N_E:
            begin
                sum_next[qsb_pkg::S_QUAD] = sum_reg[qsb_pkg::S_QUAD] - sum_reg[qsb_pkg::S_LEFT];
                rnd1_next    = 1'b1;
                em_last_next = 1'b0;
            end
            qsb_pkg::ST_R1L_B:
            begin
                q_next = sum_reg[qsb_pkg::S_RIGHT] + sum_reg[qsb_pkg::S_QUAD]
                       + ACC_BITS'(ram_rdata);
                rnd1_next    = 1'b1;
                em_last_next = 1'b1;
            end
            qsb_pkg::ST_UA1:
            begin
                add_next = (mode_reg == qsb_pkg::M_NORM) ? p_reg : ram_rdata;
            end
            qsb_pkg::ST_UA2:
            begin
                rem_next = (mode_reg == qsb_pkg::M_START) ? '0 : ram_rdata;
                if (mode_reg != qsb_pkg::M_START)
                begin
                    wi_next = wi_inc;
                end
                op_next = qsb_pkg::OP_LOUT_SUB_REM;
            end
            qsb_pkg::ST_OPA:
            begin
                zero_next = (mode_reg == qsb_pkg::M_START) && st_zero;
            end
            qsb_pkg::ST_OPB:
            begin
                op_next = op_reg + qsb_pkg::OP_W'(1);
                case (op_reg)
                    qsb_pkg::OP_LOUT_SUB_REM:
                        sum_next[qsb_pkg::S_LOUT] = sum_reg[qsb_pkg::S_LOUT] - ACC_BITS'(rem_reg);
                    qsb_pkg::OP_LIN_ADD_R:
                        sum_next[qsb_pkg::S_LIN] = sum_reg[qsb_pkg::S_LIN] + fv;
                    qsb_pkg::OP_LEFT_ADD_LIN:
                        sum_next[qsb_pkg::S_LEFT] = sum_reg[qsb_pkg::S_LEFT]
                                                  + sum_reg[qsb_pkg::S_LIN];
                    qsb_pkg::OP_LOUT_ADD_ACC:
                        sum_next[qsb_pkg::S_LOUT] = sum_reg[qsb_pkg::S_LOUT] + fv;
                    qsb_pkg::OP_LIN_SUB_RACC:
                        sum_next[qsb_pkg::S_LIN] = sum_reg[qsb_pkg::S_LIN] - fv;
                    qsb_pkg::OP_ROUT_SUB_R1:
                        sum_next[qsb_pkg::S_ROUT] = sum_reg[qsb_pkg::S_ROUT] - fv;
                    qsb_pkg::OP_RIN_ADD_NEW:
                        sum_next[qsb_pkg::S_RIN] = sum_reg[qsb_pkg::S_RIN] + ACC_BITS'(add_reg);
                    qsb_pkg::OP_RIGHT_ADD_RIN:
                        sum_next[qsb_pkg::S_RIGHT] = sum_reg[qsb_pkg::S_RIGHT]
                                                   + sum_reg[qsb_pkg::S_RIN];
                    qsb_pkg::OP_ROUT_ADD_RPACC:
                        sum_next[qsb_pkg::S_ROUT] = sum_reg[qsb_pkg::S_ROUT] + fv;
                    qsb_pkg::OP_RIN_SUB_2RACC:
                        sum_next[qsb_pkg::S_RIN] = sum_reg[qsb_pkg::S_RIN] - fv;
                    qsb_pkg::OP_QUAD_ADD_RIGHT:
                    begin
                        sum_next[qsb_pkg::S_QUAD] = sum_reg[qsb_pkg::S_QUAD]
                                                  + sum_reg[qsb_pkg::S_RIGHT];
                        v_next = sum_reg[qsb_pkg::S_QUAD] + sum_reg[qsb_pkg::S_RIGHT];
                    end
                    qsb_pkg::OP_QUAD_SUB_LEFT:
                        sum_next[qsb_pkg::S_QUAD] = sum_reg[qsb_pkg::S_QUAD]
                                                  - sum_reg[qsb_pkg::S_LEFT];
                    qsb_pkg::OP_LEFT_SUB_LOUT:
                        sum_next[qsb_pkg::S_LEFT] = sum_reg[qsb_pkg::S_LEFT]
                                                  - sum_reg[qsb_pkg::S_LOUT];
                    qsb_pkg::OP_RIGHT_SUB_ROUT:
                        sum_next[qsb_pkg::S_RIGHT] = sum_reg[qsb_pkg::S_RIGHT]
                                                   - sum_reg[qsb_pkg::S_ROUT];
                    default:
                        op_next = op_reg;
                endcase
            end
            qsb_pkg::ST_FIN:
            begin
                rnd1_next    = 1'b0;
                em_last_next = (mode_reg == qsb_pkg::M_DRAIN)
                            && (XW'(cnt_reg) + XW'(1) == xr);
                if (mode_reg == qsb_pkg::M_START)
                begin
                    step_next = step_reg + AW'(1);
                    q_next = sum_reg[qsb_pkg::S_QUAD] + sum_reg[qsb_pkg::S_LOUT]
                           + sum_reg[qsb_pkg::S_LEFT];
                    if (step_last)
                    begin
                        wi_next = '0;
                    end
                end
                else
                begin
                    q_next = v_reg;
                end
            end
            qsb_pkg::ST_MUL:
            begin
                prod_next = PRW'(q_reg) * PRW'(weight_multiplier);
            end
            qsb_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_pixel_next = emit_val;
                    out_last_next  = em_last_reg;
                    if (em_last_reg)
                    begin
                        ps_next  = '0;
                        wi_next  = '0;
                        sum_next = '{default: '0};
                    end
                    else if (mode_reg == qsb_pkg::M_DRAIN)
                    begin
                        cnt_next = cnt_reg + PSW'(1);
                    end
                    else if (last_reg && !r_one)
                    begin
                        cnt_next  = '0;
                        mode_next = qsb_pkg::M_DRAIN;
                    end
                end
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qsb_pkg::ST_IDLE;
            mode_reg      <= qsb_pkg::M_NORM;
            sum_reg       <= '{default: '0};
            wi_reg        <= '0;
            ps_reg        <= '0;
            lr_reg        <= '0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            op_reg        <= '0;
            em_last_reg   <= 1'b0;
            rnd1_reg      <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            sum_reg       <= sum_next;
            wi_reg        <= wi_next;
            ps_reg        <= ps_next;
            lr_reg        <= lr_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            em_last_reg   <= em_last_next;
            rnd1_reg      <= rnd1_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        add_reg       <= add_next;
        rem_reg       <= rem_next;
        zero_reg      <= zero_next;
        v_reg         <= v_next;
        q_reg         <= q_next;
        prod_reg      <= prod_next;
        out_pixel_reg <= out_pixel_next;
        out_last_reg  <= out_last_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.pixel_out = out_pixel_reg;
    assign out_ch.last_out  = out_last_reg;

endmodule

>>> design/quadratic_stack_blur_line.sv
// quadratic_stack_blur_line: top level, configuration registers, front queue and back sequencer
// depends on qsb_pkg, qsb_if, qsb_front and qsb_back
//
// usage:
// pixels of one line enter on in_ch (valid/ready), the final one with last_in set;
// blurred pixels leave on out_ch, the final one of a line with last_out set
// the user writes registers radius, weight_multiplier and weight_shift on cfg_we, cfg_index,
// cfg_data only while the block is idle, not enforced; radius is taken at each line start
// a four word input queue lets pixels be taken while the back end works or stalls
// nothing comes out until radius+1 pixels are in; that pixel runs the startup fill,
// 2r+1 passes through the window ram at radius 2 and up, then one word out
// each later pixel gives one word: at radius 2 and up fourteen sum updates, each an OPA
// read and an OPB update, as the window ram has a single read port; at radius 1 the
// states R1N_A to R1N_E
// the last pixel adds r more words
// a stalled out_ch holds the output word; the back end waits, the queue keeps filling
// reset clears the line state and the sums; the window ram is not cleared
module quadratic_stack_blur_line #(
    parameter int MAX_RAD    = 20,
    parameter int PIXEL_BITS = 8,
    parameter int ACC_BITS   = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [qsb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qsb_pkg::CFG_W-1:0]        cfg_data,
    qsb_in_if.sink                           in_ch,
    qsb_out_if.source                        out_ch
);

    logic [qsb_pkg::RAD_W-1:0]   radius_reg, radius_next;
    logic [qsb_pkg::MULT_W-1:0]  mult_reg, mult_next;
    logic [qsb_pkg::SHIFT_W-1:0] shift_reg, shift_next;

    logic                  pop_valid, pop_ready, pop_last;
    logic [PIXEL_BITS-1:0] pop_pixel;

    always_comb
    begin
        radius_next = radius_reg;
        mult_next   = mult_reg;
        shift_next  = shift_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                qsb_pkg::REG_RADIUS:       radius_next = cfg_data[qsb_pkg::RAD_W-1:0];
                qsb_pkg::REG_WEIGHT_MULT:  mult_next   = cfg_data[qsb_pkg::MULT_W-1:0];
                qsb_pkg::REG_WEIGHT_SHIFT: shift_next  = cfg_data[qsb_pkg::SHIFT_W-1:0];
                default:                   radius_next = radius_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= qsb_pkg::RADIUS_RST;
            mult_reg   <= qsb_pkg::MULT_RST;
            shift_reg  <= qsb_pkg::SHIFT_RST;
        end
        else
        begin
            radius_reg <= radius_next;
            mult_reg   <= mult_next;
            shift_reg  <= shift_next;
        end
    end

    qsb_front #(
        .PIXEL_BITS(PIXEL_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_pixel(pop_pixel),
        .pop_last (pop_last)
    );

    qsb_back #(
        .MAX_RAD   (MAX_RAD),
        .PIXEL_BITS(PIXEL_BITS),
        .ACC_BITS  (ACC_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_pixel        (pop_pixel),
        .pop_last         (pop_last),
        .radius           (radius_reg),
        .weight_multiplier(mult_reg),
        .weight_shift     (shift_reg),
        .out_ch           (out_ch)
    );

endmodule

>>> design/qsb_checker.sv
// qsb_checker: port level checks of the blur block, bound to the top level
// depends on quadratic_stack_blur_line
module qsb_checker #(
    parameter int PIXEL_BITS = 8
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [PIXEL_BITS-1:0] pixel_out,
    input logic                  last_out
);

    logic seen_reg, seen_next;

    assign seen_next = seen_reg || (in_valid && in_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_out) && $stable(last_out))
        else $error("output word changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_reg)
        else $error("output word without any input");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind quadratic_stack_blur_line qsb_checker #(
    .PIXEL_BITS(PIXEL_BITS)
) u_qsb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .pixel_out(out_ch.pixel_out),
    .last_out (out_ch.last_out)
);

>>> bench/quadratic_stack_blur_line_tb.sv
// quadratic_stack_blur_line_tb: self-checking bench for the quadratic stack blur line block
// depends on qsb_pkg, qsb_if and quadratic_stack_blur_line; every output word is checked
// against a line-level predictor, with directed lines first and random lines after
module quadratic_stack_blur_line_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_R   = 20;
    localparam int WIN_LEN = 2 * MAX_R + 1;
    localparam int N_RAND  = 470;

    typedef struct packed {
        logic [7:0] pix;
        logic       last;
    } blur_word_t;

    typedef struct {
        int rad;
        int mult;
        int shift;
        int pix;
        bit last;
        bit typed;
        int n;
        int epix;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [qsb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [qsb_pkg::CFG_W-1:0] cfg_data;

    qsb_in_if #(.PIXEL_BITS(8)) in_ch();
    qsb_out_if #(.PIXEL_BITS(8)) out_ch();

    quadratic_stack_blur_line #(
        .MAX_RAD(MAX_R),
        .PIXEL_BITS(8),
        .ACC_BITS(32)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // predictor state
    logic [7:0] win_mem [WIN_LEN];
    logic [31:0] sums [qsb_pkg::NUM_SUMS];
    int widx;
    int seen;
    int lrad;
    logic [qsb_pkg::RAD_W-1:0] cur_rad;
    logic [qsb_pkg::MULT_W-1:0] cur_mult;
    logic [qsb_pkg::SHIFT_W-1:0] cur_shift;

    blur_word_t blur_expect [$];
    blur_word_t line_words [$];

    int errors;
    int n_sent;
    int n_words;
    int n_lines;
    int rx_hold;
    bit idle_en;
    bit dir_typed;
    int dir_n;
    int dir_pix;

    dir_row_t dir_rows [23] = '{
        '{2, 5461, 16, 77, 1, 1, 0, 0},
        '{2, 5461, 16, 0, 0, 0, 0, 0},
        '{2, 5461, 16, 255, 0, 0, 0, 0},
        '{2, 5461, 16, 255, 0, 0, 0, 0},
        '{2, 5461, 16, 0, 1, 0, 0, 0},
        '{1, 5461, 16, 255, 0, 1, 0, 0},
        '{1, 5461, 16, 255, 0, 1, 1, 255},
        '{1, 5461, 16, 255, 1, 0, 0, 0},
        '{1, 5461, 16, 0, 0, 0, 0, 0},
        '{1, 5461, 16, 128, 0, 0, 0, 0},
        '{1, 5461, 16, 1, 1, 0, 0, 0},
        '{0, 5461, 16, 99, 1, 1, 0, 0},
        '{31, 5461, 16, 5, 0, 1, 0, 0},
        '{21, 5461, 16, 6, 1, 1, 0, 0},
        '{3, 65535, 0, 255, 0, 1, 0, 0},
        '{3, 65535, 0, 255, 0, 1, 0, 0},
        '{3, 65535, 0, 255, 0, 1, 0, 0},
        '{3, 65535, 0, 255, 1, 0, 0, 0},
        '{4, 0, 31, 255, 0, 1, 0, 0},
        '{4, 0, 31, 255, 0, 1, 0, 0},
        '{4, 0, 31, 255, 0, 1, 0, 0},
        '{4, 0, 31, 255, 0, 1, 0, 0},
        '{4, 0, 31, 200, 1, 0, 0, 0}
    };

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int ring_wrap(int x, int bs);
        return (x >= bs) ? x - bs : x;
    endfunction

    function automatic logic [31:0] fetch_px(bit startup, int step, int x);
        int bs;
        int t;
        bs = 2 * lrad + 1;
        if (startup)
        begin
            t = x + step + 1;
            if (t < bs)
                return 32'd0;
            return {24'd0, win_mem[t - bs]};
        end
        return {24'd0, win_mem[ring_wrap(widx + x, bs)]};
    endfunction

    function automatic logic [31:0] sum_update(logic [31:0] rem, logic [31:0] add,
                                               bit startup, int step);
        int r;
        int acc;
        logic [31:0] v;
        r = lrad;
        acc = r >> 1;
        sums[qsb_pkg::S_LOUT]  -= rem;
        sums[qsb_pkg::S_LIN]   += fetch_px(startup, step, r);
        sums[qsb_pkg::S_LEFT]  += sums[qsb_pkg::S_LIN];
        sums[qsb_pkg::S_LOUT]  += fetch_px(startup, step, acc);
        sums[qsb_pkg::S_LIN]   -= fetch_px(startup, step, r - acc);
        sums[qsb_pkg::S_ROUT]  -= fetch_px(startup, step, r - 1);
        sums[qsb_pkg::S_RIN]   += add;
        sums[qsb_pkg::S_RIGHT] += sums[qsb_pkg::S_RIN];
        sums[qsb_pkg::S_ROUT]  += fetch_px(startup, step, r + acc);
        sums[qsb_pkg::S_RIN]   -= fetch_px(startup, step, 2 * r - acc);
        sums[qsb_pkg::S_QUAD]  += sums[qsb_pkg::S_RIGHT];
        v = sums[qsb_pkg::S_QUAD];
        sums[qsb_pkg::S_QUAD]  -= sums[qsb_pkg::S_LEFT];
        sums[qsb_pkg::S_LEFT]  -= sums[qsb_pkg::S_LOUT];
        sums[qsb_pkg::S_RIGHT] -= sums[qsb_pkg::S_ROUT];
        return v;
    endfunction

    function automatic logic [7:0] weight_scale(logic [31:0] q);
        logic [63:0] v;
        v = {32'd0, q} * {48'd0, cur_mult};
        if (cur_shift != 0)
            v = (v + (64'd1 << (cur_shift - 1))) >> cur_shift;
        return v[7:0];
    endfunction

    function automatic logic [7:0] round_plain(logic [31:0] v);
        logic [32:0] t;
        t = {1'b0, v} + 33'd2;
        return t[9:2];
    endfunction

    function automatic logic [31:0] ring_push(logic [7:0] p, int bs);
        logic [31:0] old;
        old = {24'd0, win_mem[widx]};
        win_mem[widx] = p;
        widx = ring_wrap(widx + 1, bs);
        return old;
    endfunction

    function automatic void clear_line();
        widx = 0;
        seen = 0;
        for (int k = 0; k < qsb_pkg::NUM_SUMS; k++)
            sums[k] = 32'd0;
    endfunction

    function automatic void emit_word(logic [7:0] v);
        blur_word_t w;
        w.pix = v;
        w.last = 1'b0;
        line_words.push_back(w);
    endfunction

    // returns the number of words the pixel causes, queued on blur_expect
    function automatic int blur_predict(logic [7:0] p, bit last);
        int r;
        int bs;
        int nxt;
        int j;
        logic [31:0] old;
        logic [31:0] rem;
        logic [7:0] q;
        blur_word_t w;
        line_words.delete();
        if (seen == 0)
        begin
            lrad = cur_rad;
            clear_line();
        end
        r = lrad;
        if (r == 0 || r > MAX_R)
            return 0;
        bs = 2 * r + 1;
        if (seen < r + 1)
        begin
            win_mem[r + seen] = p;
            win_mem[r - seen] = p;
            seen++;
            if (seen < r + 1)
            begin
                if (last)
                    clear_line();
                return 0;
            end
            widx = 0;
            if (r == 1)
            begin
                sums[qsb_pkg::S_LEFT] = {24'd0, win_mem[0]} + {24'd0, win_mem[1]};
                sums[qsb_pkg::S_RIGHT] = {24'd0, win_mem[2]};
                sums[qsb_pkg::S_QUAD] = sums[qsb_pkg::S_LEFT];
                emit_word(round_plain(2 * {24'd0, win_mem[0]} + 2 * {24'd0, win_mem[1]}));
            end
            else
            begin
                for (int i = 0; i < bs; i++)
                    void'(sum_update(32'd0, {24'd0, win_mem[i]}, 1'b1, i));
                widx = 0;
                emit_word(weight_scale(sums[qsb_pkg::S_QUAD] + sums[qsb_pkg::S_LOUT]
                                       + sums[qsb_pkg::S_LEFT]));
            end
        end
        else if (r == 1)
        begin
            old = ring_push(p, bs);
            sums[qsb_pkg::S_LEFT] -= old;
            nxt = ring_wrap(widx + 1, bs);
            rem = {24'd0, win_mem[nxt]};
            sums[qsb_pkg::S_RIGHT] += {24'd0, p};
            sums[qsb_pkg::S_LEFT] += rem;
            sums[qsb_pkg::S_QUAD] += sums[qsb_pkg::S_RIGHT];
            sums[qsb_pkg::S_RIGHT] -= rem;
            emit_word(round_plain(sums[qsb_pkg::S_QUAD]));
            sums[qsb_pkg::S_QUAD] -= sums[qsb_pkg::S_LEFT];
        end
        else
        begin
            old = ring_push(p, bs);
            emit_word(weight_scale(sum_update(old, {24'd0, p}, 1'b0, 0)));
        end
        if (last)
        begin
            if (r == 1)
            begin
                nxt = ring_wrap(widx + 1, bs);
                emit_word(round_plain(sums[qsb_pkg::S_RIGHT] + sums[qsb_pkg::S_QUAD]
                                      + {24'd0, win_mem[nxt]}));
            end
            else
            begin
                for (int i = 0; i < r; i++)
                begin
                    j = ring_wrap(bs + widx - 2 * (i + 1), bs);
                    q = win_mem[j];
                    old = ring_push(q, bs);
                    emit_word(weight_scale(sum_update(old, {24'd0, q}, 1'b0, 0)));
                end
            end
            line_words[$].last = 1'b1;
            clear_line();
        end
        foreach (line_words[i])
        begin
            w = line_words[i];
            blur_expect.push_back(w);
        end
        return line_words.size();
    endfunction

    // monitor: check output words, then predict from the accepted input word
    always @(posedge clk)
    begin
        blur_word_t e;
        int cnt;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                n_words++;
                if (blur_expect.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, expected none, got pix %0d last %b",
                             $time, out_ch.pixel_out, out_ch.last_out);
                end
                else
                begin
                    e = blur_expect.pop_front();
                    if (out_ch.pixel_out !== e.pix)
                    begin
                        errors++;
                        $display("%0t: pixel_out expected %0d, got %0d",
                                 $time, e.pix, out_ch.pixel_out);
                    end
                    if (out_ch.last_out !== e.last)
                    begin
                        errors++;
                        $display("%0t: last_out expected %b, got %b",
                                 $time, e.last, out_ch.last_out);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                cnt = blur_predict(in_ch.pixel_in, in_ch.last_in);
                if (dir_typed && (cnt != dir_n || (cnt == 1 && blur_expect[$].pix != dir_pix)))
                begin
                    errors++;
                    $display("%0t: directed word count expected %0d pix %0d, got %0d pix %0d",
                             $time, dir_n, dir_pix, cnt,
                             (cnt > 0) ? int'(blur_expect[$].pix) : 0);
                end
            end
        end
    end

    // receiver
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (rx_hold) @(negedge clk);
                rx_hold = 0;
            end
            gap = idle_en ? $urandom_range(0, 10) : 0;
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            @(negedge clk);
        end
    end

    task automatic send_pixel(int p, bit last);
        int gap;
        gap = idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.pixel_in <= p[7:0];
        in_ch.last_in <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        n_sent++;
        if (last)
            n_lines++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (blur_expect.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_reg(logic [qsb_pkg::CFG_IDX_W-1:0] idx, int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[qsb_pkg::CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            qsb_pkg::REG_RADIUS:       cur_rad = val[qsb_pkg::RAD_W-1:0];
            qsb_pkg::REG_WEIGHT_MULT:  cur_mult = val[qsb_pkg::MULT_W-1:0];
            qsb_pkg::REG_WEIGHT_SHIFT: cur_shift = val[qsb_pkg::SHIFT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int rad, int mult, int shift);
        wait_idle();
        write_reg(qsb_pkg::REG_RADIUS, rad);
        write_reg(qsb_pkg::REG_WEIGHT_MULT, mult);
        write_reg(qsb_pkg::REG_WEIGHT_SHIFT, shift);
    endtask

    function automatic int rand_pixel();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) != 0) ? 255 : 0;
        return $urandom_range(0, 255);
    endfunction

    initial
    begin
        #30_000_000;
        $display("quadratic_stack_blur_line: mismatch");
        $finish;
    end

    initial
    begin
        int rad;
        int mult;
        int shift;
        int len;
        int phase;
        int eff;
        in_ch.valid = 1'b0;
        in_ch.pixel_in = '0;
        in_ch.last_in = 1'b0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        errors = 0;
        n_sent = 0;
        n_words = 0;
        n_lines = 0;
        rx_hold = 0;
        idle_en = 1'b1;
        dir_typed = 1'b0;
        cur_rad = qsb_pkg::RADIUS_RST;
        cur_mult = qsb_pkg::MULT_RST;
        cur_shift = qsb_pkg::SHIFT_RST;
        foreach (win_mem[i])
            win_mem[i] = 8'd0;
        lrad = 0;
        clear_line();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].rad != cur_rad || dir_rows[i].mult != cur_mult ||
                dir_rows[i].shift != cur_shift)
                set_config(dir_rows[i].rad, dir_rows[i].mult, dir_rows[i].shift);
            dir_typed = dir_rows[i].typed;
            dir_n = dir_rows[i].n;
            dir_pix = dir_rows[i].epix;
            send_pixel(dir_rows[i].pix, dir_rows[i].last);
        end
        dir_typed = 1'b0;

        phase = 0;
        while (n_sent < N_RAND + 23)
        begin
            case ($urandom_range(0, 9))
                0:       rad = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(21, 31);
                1:       rad = 20;
                2, 3:    rad = 1;
                default: rad = $urandom_range(2, 6);
            endcase
            case ($urandom_range(0, 5))
                0:       mult = 0;
                1:       mult = 65535;
                default: mult = $urandom_range(0, 65535);
            endcase
            shift = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 31);
            set_config(rad, mult, shift);
            idle_en = ($urandom_range(0, 3) != 0);
            if (phase == 3)
                rx_hold = 400;
            phase++;
            if (rad == 0 || rad > MAX_R)
            begin
                repeat ($urandom_range(1, 3))
                    send_pixel(rand_pixel(), $urandom_range(0, 1));
                continue;
            end
            repeat ($urandom_range(1, 4))
            begin
                eff = (rad == 20) ? 21 : rad + 1;
                if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(1, rad);
                else if (rad == 20)
                    len = $urandom_range(21, 24);
                else
                    len = $urandom_range(eff, rad + 12);
                for (int k = 0; k < len; k++)
                    send_pixel(rand_pixel(), k == len - 1);
            end
        end

        wait_idle();
        $display("covered %0d pixels in %0d lines, %0d blurred words checked",
                 n_sent, n_lines, n_words);
        $display("radius 1, 2..6 and 20, invalid radii, short lines, zero shift, stalls");
        if (errors == 0)
            $display("quadratic_stack_blur_line: match");
        else
            $display("quadratic_stack_blur_line: mismatch");
        $finish;
    end

endmodule
